// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: operation and error
// codes, stream word layouts and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  // field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned ErrW   = 2;

  // stream word widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // error codes
  localparam logic [ErrW-1:0] ERR_OK         = 2'd0;
  localparam logic [ErrW-1:0] ERR_POP_EMPTY  = 2'd1;
  localparam logic [ErrW-1:0] ERR_PUSH_FULL  = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;   // insert din in sorted position
    logic pop;    // shift everything one cell toward the head
  } spq_ctrl_t;

endpackage

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted store. Compares its entry against the pushed value
// and either keeps it, takes the new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                                clk,
  input  spq_pkg::spq_ctrl_t                  ctrl,
  input  logic                                valid,       // slot is below count
  input  logic signed [spq_pkg::ValueW-1:0]   din,         // value being pushed
  input  logic                                left_flag,   // left slot stays put
  input  logic signed [spq_pkg::ValueW-1:0]   left_entry,
  input  logic signed [spq_pkg::ValueW-1:0]   right_entry,
  output logic                                flag,        // this slot stays put
  output logic signed [spq_pkg::ValueW-1:0]   entry,
  output logic signed [spq_pkg::ValueW-1:0]   entry_next
);

  // stored entry stays when it is valid and not larger than the new value
  assign flag = valid && (entry <= din);

  // next entry selection
  always_comb begin
    priority if (ctrl.push) begin
      if (flag) begin
        entry_next = entry;
      end else if (left_flag) begin
        entry_next = din;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = right_entry;
    end else begin
      entry_next = entry;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Min-priority queue kept as a row of DEPTH compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one operation per transaction: push of a
//   signed 32-bit value, or pop of the smallest entry. Every operation gives
//   exactly one result transaction on m_axis with the head value, a head
//   valid flag, the entry count and an error code, all taken after the
//   operation. Equal values leave in arrival order.
//   The result is registered at the edge that accepts the operation. Throughput
//   is one operation per cycle while m_axis takes results; every cell compares
//   against the pushed value in parallel and shifts by one slot, so the cost
//   per operation is one 32-bit compare plus a 4-way select.
//   Pop on an empty queue and push into a full queue leave the store as is
//   and report an error code.
//   Reset empties the queue (count cleared, cell contents left as they are).
//   When m_axis stalls, the held result stays and s_axis_tready drops until
//   the result is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] opcode, [32:1] value, [39:33] zero
  input  logic [spq_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] head_value, [32] head_valid, [37:33] entry_count, [39:38] error_code
  output logic [spq_pkg::OutDataW-1:0]    m_axis_tdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                               accept;
  logic                               opcode;
  logic signed [spq_pkg::ValueW-1:0]  value;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  logic                               full;
  logic                               empty;
  logic [spq_pkg::ErrW-1:0]           err;
  spq_pkg::spq_ctrl_t                 ctrl;
  logic [CW+4:0]                      count_ext;
  logic signed [spq_pkg::ValueW-1:0]  head_next;

  logic                               flags   [DEPTH];
  logic signed [spq_pkg::ValueW-1:0]  entries [DEPTH];
  logic signed [spq_pkg::ValueW-1:0]  nexts   [DEPTH];

  // input unpacking and handshake
  assign opcode        = s_axis_tdata[0];
  assign value         = s_axis_tdata[spq_pkg::ValueW:1];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // operation decode
  always_comb begin
    ctrl.push  = 1'b0;
    ctrl.pop   = 1'b0;
    err        = spq_pkg::ERR_OK;
    count_next = count;
    if (accept) begin
      if (opcode == spq_pkg::OP_PUSH) begin
        if (full) begin
          err = spq_pkg::ERR_PUSH_FULL;
        end else begin
          ctrl.push  = 1'b1;
          count_next = count + 1'b1;
        end
      end else begin
        if (empty) begin
          err = spq_pkg::ERR_POP_EMPTY;
        end else begin
          ctrl.pop   = 1'b1;
          count_next = count - 1'b1;
        end
      end
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                               left_flag;
    logic signed [spq_pkg::ValueW-1:0]  left_entry;
    logic signed [spq_pkg::ValueW-1:0]  right_entry;

    if (i == 0) begin : g_first
      assign left_flag  = 1'b1;
      assign left_entry = value;
    end else begin : g_mid
      assign left_flag  = flags[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (count > CW'(i)),
      .din         (value),
      .left_flag   (left_flag),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .flag        (flags[i]),
      .entry       (entries[i]),
      .entry_next  (nexts[i])
    );
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result fields taken from the next state
  assign head_next = (count_next != '0) ? nexts[0] : '0;
  assign count_ext = {5'd0, count_next};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {err, count_ext[4:0], (count_next != '0), head_next};
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue testbench
// Drives push and pop transactions into the queue and checks every result
// against a behavioral sorted-store model of its own: head value, head valid,
// entry count and error code. A directed opening covers the value extremes,
// equal values, pop on an empty queue and push into a full queue. Random
// fill, drain and mixed bursts follow, under three idling patterns on the
// input and output streams.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH      = 16;
  localparam int          NUM_RANDOM  = 1300;
  localparam int          CYCLE_LIMIT = 400000;

  // one expected result, fields at the block's widths
  typedef struct packed {
    logic [spq_pkg::ErrW-1:0]          err;
    logic [spq_pkg::CountW-1:0]        count;
    logic                              valid;
    logic signed [spq_pkg::ValueW-1:0] head;
  } spq_result_t;

  // sorted-store model plus the queue of results still owed by the block
  class spq_scoreboard;
    logic signed [spq_pkg::ValueW-1:0] entries[$];
    spq_result_t                       owed[$];
    int                                depth;
    int                                errors;

    function new(int d);
      depth  = d;
      errors = 0;
    endfunction

    // apply an accepted operation to the model and queue its result
    function void note_op(logic op, logic signed [spq_pkg::ValueW-1:0] v);
      spq_result_t r;
      int          pos;
      r.err = spq_pkg::ERR_OK;
      if (op == spq_pkg::OP_PUSH) begin
        if (entries.size() >= depth) begin
          r.err = spq_pkg::ERR_PUSH_FULL;
        end else begin
          // new value goes behind every entry less than or equal to it
          pos = 0;
          while (pos < entries.size() && entries[pos] <= v) pos++;
          entries.insert(pos, v);
        end
      end else begin
        if (entries.size() == 0) r.err = spq_pkg::ERR_POP_EMPTY;
        else void'(entries.pop_front());
      end
      r.valid = (entries.size() != 0);
      r.head  = r.valid ? entries[0] : '0;
      r.count = spq_pkg::CountW'(entries.size());
      owed.push_back(r);
    endfunction

    task report_mismatch(string what, logic [spq_pkg::ValueW-1:0] got,
                         logic [spq_pkg::ValueW-1:0] want);
      errors++;
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // compare one accepted result with the oldest expectation
    task check_result(logic [spq_pkg::OutDataW-1:0] d);
      spq_result_t want;
      if (owed.size() == 0) begin
        report_mismatch("result with nothing owed, tdata", d[31:0], '0);
      end else begin
        want = owed.pop_front();
        if (d[31:0] !== want.head) report_mismatch("head_value", d[31:0], want.head);
        if (d[32] !== want.valid) report_mismatch("head_valid", d[32], want.valid);
        if (d[37:33] !== want.count) report_mismatch("entry_count", d[37:33], want.count);
        if (d[39:38] !== want.err) report_mismatch("error_code", d[39:38], want.err);
      end
    endtask

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [spq_pkg::InDataW-1:0]  s_axis_tdata;   // [0] opcode, [32:1] value, [39:33] zero
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // [31:0] head, [32] valid, [37:33] count, [39:38] err
  logic [spq_pkg::OutDataW-1:0] m_axis_tdata;

  spq_scoreboard sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            cycle_count;

  sorted_priority_queue #(
    .DEPTH(QDEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // one operation transaction, entered and left at a falling edge
  task automatic send_op(input logic op, input logic [spq_pkg::ValueW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'b0, v, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_op(op, v);
    @(negedge clk);
  endtask

  // values: extremes, a narrow band that repeats often, or anything
  function automatic logic [spq_pkg::ValueW-1:0] pick_value();
    logic [spq_pkg::ValueW-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      1, 2, 3: v = spq_pkg::ValueW'($signed($urandom_range(8)) - 4);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // idling pattern by progress through the random part
  task automatic set_idling(input int sent);
    if (sent < NUM_RANDOM / 3) begin
      send_idle_pct = 14;
      recv_idle_pct = 52;
    end else if (sent < 2 * NUM_RANDOM / 3) begin
      send_idle_pct = 52;
      recv_idle_pct = 14;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  logic [spq_pkg::ValueW-1:0] fill_values[16] = '{
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
    32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'hffff_fffe,
    32'h7fff_fffe, 32'h8000_0001, 32'haaaa_aaaa, 32'h5555_5555,
    32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678
  };

  initial begin
    int sent;
    int burst;
    int push_pct;
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cycle_count   = 0;
    sent          = 0;
    sb            = new(QDEPTH);
    set_idling(0);

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: pop on empty, fill with extremes and equal values,
    // push into a full queue, then take a few back out
    send_op(spq_pkg::OP_POP, 32'hdead_beef);
    foreach (fill_values[i]) send_op(spq_pkg::OP_PUSH, fill_values[i]);
    send_op(spq_pkg::OP_PUSH, 32'hffff_ffff);
    repeat (5) send_op(spq_pkg::OP_POP, $urandom);

    // random fill, drain and mixed bursts
    while (sent < NUM_RANDOM) begin
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      burst = $urandom_range(10, 40);
      for (int i = 0; i < burst && sent < NUM_RANDOM; i++) begin
        set_idling(sent);
        send_op(($urandom_range(99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP,
                pick_value());
        sent++;
      end
    end
    s_axis_tvalid = 1'b0;

    // drain outstanding results, then a short tail
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
